// ===== design/fcdc_pkg.sv =====
package fcdc_pkg;

	// Default values of the top-level parameters.
	localparam int SOURCE_CLOCK_HZ_DEF = 500000000;
	localparam int FRACTION_BITS_DEF   = 12;

	// Field widths.
	localparam int CARRIER_W = 29;
	localparam int TONE_W    = 16;
	localparam int DEN_W     = 30;
	localparam int WORD_W    = 31;
	localparam int PART_W    = 12;
	localparam int INT_W     = 12;

	// Divider register word password and its position.
	localparam logic [7:0] PASSWORD       = 8'h5a;
	localparam int         PASSWORD_SHIFT = 24;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CARRIER = 1'b0;

	// Control bits that travel down the cell chain with each beat.
	typedef struct packed {
		logic valid;
		logic neg;
	} fcdc_ctl_t;

	// One result beat.
	typedef struct packed {
		logic [WORD_W-1:0] divider_word;
		logic [PART_W-1:0] integer_part;
		logic [PART_W-1:0] fraction_part;
		logic              out_of_range;
	} fcdc_result_t;

endpackage

// ===== design/fcdc_in_if.sv =====
interface fcdc_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [fcdc_pkg::TONE_W-1:0] tone_offset;

	modport source(output valid, output tone_offset, input ready);
	modport sink(input valid, input tone_offset, output ready);
endinterface

// ===== design/fcdc_out_if.sv =====
interface fcdc_out_if;
	logic                        valid;
	logic                        ready;
	logic [fcdc_pkg::WORD_W-1:0] divider_word;
	logic [fcdc_pkg::PART_W-1:0] integer_part;
	logic [fcdc_pkg::PART_W-1:0] fraction_part;
	logic                        out_of_range;

	modport source(output valid, output divider_word, output integer_part,
		output fraction_part, output out_of_range, input ready);
	modport sink(input valid, input divider_word, input integer_part,
		input fraction_part, input out_of_range, output ready);
endinterface

// ===== design/fractional_clock_divider_calc_top.sv =====
// Fractional clock divider word calculator.
// Each beat on req carries a signed tone offset in hertz. It is added to the
// carrier frequency register, and the source clock is divided by the sum as an
// exact fixed-point quotient floor(SOURCE_CLOCK_HZ * 2^FRACTION_BITS / sum).
// Each request beat yields exactly one beat on rsp with the packed divider
// word (password 0x5a, integer part, fraction part), the two parts alone and
// an out_of_range flag. When the sum is not positive or the integer part is
// outside 1..4095, out_of_range is set and every other field is zero.
// The accepting edge loads the sum register; then one restoring-division cell
// per quotient bit (FRACTION_BITS + 13 cells, the first one detecting
// overflow) and the output register follow before rsp.valid. Throughput is
// one beat per cycle while the skid entry is empty. The carrier register is
// written over the APB port (byte address 0); the user must write it only
// while the block is idle, as the block itself does not enforce this. It
// resets to zero. Reset empties the whole pipeline.
// When the receiver stalls, the result is held in the output register and
// the chain keeps moving; once a second result lands in the skid entry, the
// chain and req.ready hold until rsp drains.
module fractional_clock_divider_calc_top #(
	parameter int SOURCE_CLOCK_HZ = fcdc_pkg::SOURCE_CLOCK_HZ_DEF,
	parameter int FRACTION_BITS   = fcdc_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcdc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fcdc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fcdc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	fcdc_in_if.sink                         req,
	fcdc_out_if.source                      rsp
);

	// Quotient bits kept, plus one overflow bit on top.
	localparam int QW  = FRACTION_BITS + fcdc_pkg::INT_W;
	localparam int QN  = QW + 1;
	// Width of the numerator and of the divisor shifted to the top cell.
	localparam int NW  = $clog2(SOURCE_CLOCK_HZ + 1) + FRACTION_BITS;
	localparam int DSW = fcdc_pkg::DEN_W + QW;
	localparam int RW  = (NW > DSW) ? NW : DSW;
	localparam logic [RW-1:0] NUM = RW'(64'(SOURCE_CLOCK_HZ) << FRACTION_BITS);

	// Carrier register and APB access.
	logic [fcdc_pkg::CARRIER_W-1:0] carrier_q;
	logic                           reg_sel;

	assign reg_sel = (paddr[2] == fcdc_pkg::REG_CARRIER);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			carrier_q <= pwdata[fcdc_pkg::CARRIER_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = fcdc_pkg::APB_DATA_W'(carrier_q);
		end
	end

	// Whole chain advances together unless the skid entry is occupied.
	logic buf_full;
	logic en;

	assign en        = !buf_full;
	assign req.ready = en;

	// Sum stage: carrier plus sign-extended tone, 31-bit two's complement.
	logic [fcdc_pkg::DEN_W:0]   sum_w;
	fcdc_pkg::fcdc_ctl_t        ctl_s1;
	logic [fcdc_pkg::DEN_W-1:0] den_s1;

	assign sum_w = {2'b00, carrier_q}
		+ {{(fcdc_pkg::DEN_W + 1 - fcdc_pkg::TONE_W){req.tone_offset[fcdc_pkg::TONE_W-1]}},
			req.tone_offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= req.valid;
			ctl_s1.neg   <= sum_w[fcdc_pkg::DEN_W] || (sum_w == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= sum_w[fcdc_pkg::DEN_W-1:0];
		end
	end

	// Division chain. Cell k compares against the divisor shifted by QW - k,
	// so the first cell's bit says the quotient does not fit in QW bits.
	fcdc_pkg::fcdc_ctl_t ctl_c [QN+1];
	logic [RW-1:0]       rem_c [QN+1];
	logic [RW-1:0]       dsh_c [QN+1];
	logic [QN-1:0]       quo_c [QN+1];

	assign ctl_c[0] = ctl_s1;
	assign rem_c[0] = NUM;
	assign dsh_c[0] = RW'(den_s1) << QW;
	assign quo_c[0] = '0;

	for (genvar k = 0; k < QN; k++) begin : g_cell
		fcdc_cell #(
			.RW(RW),
			.QN(QN)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (ctl_c[k]),
			.rem_i (rem_c[k]),
			.dsh_i (dsh_c[k]),
			.quo_i (quo_c[k]),
			.ctl_o (ctl_c[k+1]),
			.rem_o (rem_c[k+1]),
			.dsh_o (dsh_c[k+1]),
			.quo_o (quo_c[k+1])
		);
	end

	// Range check and packing of the divider word.
	logic [QW-1:0]             quo;
	logic [fcdc_pkg::INT_W-1:0] ipart;
	logic                      bad;
	fcdc_pkg::fcdc_result_t    res;

	assign quo   = quo_c[QN][QW-1:0];
	assign ipart = quo[QW-1:FRACTION_BITS];
	assign bad   = ctl_c[QN].neg || quo_c[QN][QN-1] || (ipart == '0);

	always_comb begin
		res = '0;
		res.out_of_range = 1'b1;
		if (!bad) begin
			res.divider_word  = fcdc_pkg::WORD_W'(32'(fcdc_pkg::PASSWORD)
				<< fcdc_pkg::PASSWORD_SHIFT) + fcdc_pkg::WORD_W'(quo);
			res.integer_part  = ipart;
			res.fraction_part = fcdc_pkg::PART_W'(quo[FRACTION_BITS-1:0]);
			res.out_of_range  = 1'b0;
		end
	end

	fcdc_pkg::fcdc_result_t out_data;

	fcdc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en && ctl_c[QN].valid),
		.push_data(res),
		.full     (buf_full),
		.out_valid(rsp.valid),
		.out_data (out_data),
		.out_ready(rsp.ready)
	);

	assign rsp.divider_word  = out_data.divider_word;
	assign rsp.integer_part  = out_data.integer_part;
	assign rsp.fraction_part = out_data.fraction_part;
	assign rsp.out_of_range  = out_data.out_of_range;

	// An out-of-range result carries nothing but the flag.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_of_range |->
			rsp.divider_word == '0 && rsp.integer_part == '0 && rsp.fraction_part == '0)
		else $error("out-of-range result with nonzero fields");

	// A good result always has a nonzero integer divisor.
	a_int_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.out_of_range |-> rsp.integer_part != '0)
		else $error("in-range result with zero integer part");

	// The skid entry only fills behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request side held while no result is offered");

endmodule

// ===== design/fcdc_cell.sv =====
// One restoring-division step: compares the remainder with the shifted
// divisor, subtracts when it fits and shifts the quotient bit in.
module fcdc_cell #(
	parameter int RW = 58,
	parameter int QN = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  fcdc_pkg::fcdc_ctl_t ctl_i,
	input  logic [RW-1:0]       rem_i,
	input  logic [RW-1:0]       dsh_i,
	input  logic [QN-1:0]       quo_i,
	output fcdc_pkg::fcdc_ctl_t ctl_o,
	output logic [RW-1:0]       rem_o,
	output logic [RW-1:0]       dsh_o,
	output logic [QN-1:0]       quo_o
);

	fcdc_pkg::fcdc_ctl_t ctl_s1;
	logic [RW-1:0]       rem_s1;
	logic [RW-1:0]       dsh_s1;
	logic [QN-1:0]       quo_s1;
	logic                fits;

	assign fits = (rem_i >= dsh_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? (rem_i - dsh_i) : rem_i;
			dsh_s1 <= dsh_i >> 1;
			quo_s1 <= {quo_i[QN-2:0], fits};
		end
	end

	assign ctl_o = ctl_s1;
	assign rem_o = rem_s1;
	assign dsh_o = dsh_s1;
	assign quo_o = quo_s1;

endmodule

// ===== design/fcdc_out_buf.sv =====
// Output register with a one-entry skid buffer. The chain is held while
// the skid entry is occupied.
module fcdc_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  fcdc_pkg::fcdc_result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	output fcdc_pkg::fcdc_result_t out_data,
	input  logic                   out_ready
);

	logic                   out_valid_q;
	fcdc_pkg::fcdc_result_t out_data_q;
	logic                   skid_valid_q;
	fcdc_pkg::fcdc_result_t skid_data_q;
	logic                   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_free) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sim/fcdc_divider_checker.sv =====
module fcdc_divider_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [fcdc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fcdc_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [fcdc_pkg::APB_DATA_W-1:0] prdata,
	fcdc_in_if                              req,
	fcdc_out_if                             rsp,
	output int                              mismatches,
	output int                              outstanding
);
	import fcdc_pkg::*;

	localparam logic [APB_ADDR_W-1:0] CARRIER_ADDR = APB_ADDR_W'(4 * int'(REG_CARRIER));
	localparam longint unsigned DIVIDEND =
		64'(SOURCE_CLOCK_HZ_DEF) << FRACTION_BITS_DEF;
	localparam longint unsigned MAX_DIVISOR = (64'd1 << INT_W) - 64'd1;

	logic [CARRIER_W-1:0] carrier = '0;
	fcdc_result_t         pending_dividers[$];
	fcdc_result_t         want;
	int                   fail_count = 0;
	int                   backlog = 0;

	assign mismatches  = fail_count;
	assign outstanding = backlog;

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	// Exact fixed-point quotient of the source clock over carrier plus tone.
	function automatic fcdc_result_t divider_for(input logic [CARRIER_W-1:0] base,
		input logic signed [TONE_W-1:0] tone);
		fcdc_result_t    r;
		longint          sum;
		longint unsigned quot;
		longint unsigned whole;
		longint unsigned frac;
		r = '0;
		r.out_of_range = 1'b1;
		sum = longint'({35'd0, base}) + longint'(tone);
		if (sum > 0) begin
			quot  = DIVIDEND / 64'(sum);
			whole = quot >> FRACTION_BITS_DEF;
			frac  = quot & ((64'd1 << FRACTION_BITS_DEF) - 64'd1);
			if (whole >= 64'd1 && whole <= MAX_DIVISOR) begin
				r.integer_part  = whole[PART_W-1:0];
				r.fraction_part = frac[PART_W-1:0];
				r.divider_word  = WORD_W'((64'(PASSWORD) << PASSWORD_SHIFT)
					+ (whole << FRACTION_BITS_DEF) + frac);
				r.out_of_range  = 1'b0;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier = '0;
			pending_dividers.delete();
			backlog = 0;
		end else begin
			if (psel && penable && pready && paddr == CARRIER_ADDR) begin
				if (pwrite) begin
					carrier = pwdata[CARRIER_W-1:0];
				end else if (prdata !== APB_DATA_W'(carrier)) begin
					report_mismatch($sformatf("carrier readback got %h want %h",
						prdata, carrier));
				end
			end
			if (req.valid && req.ready) begin
				pending_dividers.push_back(divider_for(carrier, req.tone_offset));
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_dividers.size() == 0) begin
					report_mismatch("result beat with nothing pending");
				end else begin
					want = pending_dividers.pop_front();
					if (rsp.divider_word !== want.divider_word) begin
						report_mismatch($sformatf("divider_word got %h want %h",
							rsp.divider_word, want.divider_word));
					end
					if (rsp.integer_part !== want.integer_part) begin
						report_mismatch($sformatf("integer_part got %h want %h",
							rsp.integer_part, want.integer_part));
					end
					if (rsp.fraction_part !== want.fraction_part) begin
						report_mismatch($sformatf("fraction_part got %h want %h",
							rsp.fraction_part, want.fraction_part));
					end
					if (rsp.out_of_range !== want.out_of_range) begin
						report_mismatch($sformatf("out_of_range got %b want %b",
							rsp.out_of_range, want.out_of_range));
					end
				end
			end
			backlog = pending_dividers.size();
		end
	end

endmodule

// ===== sim/fractional_clock_divider_calc_top_tb.sv =====
module fractional_clock_divider_calc_top_tb;
	import fcdc_pkg::*;

	// The carrier register sits at byte address zero; the next word is unmapped
	// and a write there must leave the carrier alone.
	localparam logic [APB_ADDR_W-1:0] CARRIER_ADDR = APB_ADDR_W'(4 * int'(REG_CARRIER));
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR   =
		APB_ADDR_W'(4 * (int'(REG_CARRIER) + 1));

	// The slowest legal run is a few hundred beats, each at worst waiting out a
	// sender gap and a receiver stall, plus a long hold and one pipeline drain
	// per phase. This limit sits far above that.
	localparam int CYCLE_LIMIT = 100000;

	// The settle time at the end covers the path from the accepting edge to the
	// result at the default fraction width, with margin.
	localparam int SETTLE_CYCLES = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int outstanding;
	int cycle_count;

	// Receiver controls. rx_steady keeps ready high for whole phases, and a
	// nonzero rx_hold_len asks the receiver for one long hold-off.
	bit rx_steady   = 1'b0;
	int rx_hold_len = 0;

	fcdc_in_if  tone_ch();
	fcdc_out_if div_ch();

	fractional_clock_divider_calc_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (tone_ch),
		.rsp     (div_ch)
	);

	// The checker watches both channels and the register port on its own, and
	// only hands back how many mismatches it saw and how many results are owed.
	fcdc_divider_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.req         (tone_ch),
		.rsp         (div_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// One register access: a setup cycle, then an access cycle that completes at
	// the first rising edge with pready high. Every access starts on a fresh
	// falling edge so psel is never dropped and raised within one time step.
	task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes the carrier and reads it straight back; the checker compares the
	// read data against its own copy of the register.
	task automatic set_carrier(input logic [APB_DATA_W-1:0] value);
		apb_access(1'b1, CARRIER_ADDR, value);
		apb_access(1'b0, CARRIER_ADDR, '0);
	endtask

	// Offers one tone beat and returns once it has been accepted. Valid stays
	// high afterward, so back-to-back calls stream one beat per cycle while ready stays high.
	task automatic send_tone(input logic [TONE_W-1:0] tone);
		@(negedge clk);
		tone_ch.valid       <= 1'b1;
		tone_ch.tone_offset <= tone;
		do @(posedge clk); while (tone_ch.ready !== 1'b1);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		tone_ch.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Drops valid and waits until every owed result has come out. Since each
	// tone yields exactly one result, the block is idle once nothing is owed.
	task automatic drain_results();
		@(negedge clk);
		tone_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (2) @(negedge clk);
	endtask

	// A run of random tones. With gaps enabled, the sender idles in short
	// bursts and now and then waits for the pipeline to empty completely.
	task automatic tone_burst(input int count, input bit gaps);
		for (int k = 0; k < count; k++) begin
			if (gaps && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 9));
			end
			if (gaps && $urandom_range(0, 79) == 0) begin
				drain_results();
			end
			send_tone(TONE_W'($urandom));
		end
		drain_results();
	endtask

	// Random carrier, biased toward both boundaries where the integer divisor
	// leaves 1..4095, toward tiny values where sums go negative, and toward the
	// full 29-bit space past the stated top. The three bits above the register
	// are random so the write must mask them off.
	function automatic logic [APB_DATA_W-1:0] pick_carrier();
		logic [31:0] c;
		case ($urandom_range(0, 4))
			0: c = $urandom_range(0, 500000000);
			1: c = $urandom_range(499960000, 500040000);
			2: c = $urandom_range(0, 162071);
			3: c = $urandom;
			default: c = $urandom_range(0, 40000);
		endcase
		return {3'($urandom), c[CARRIER_W-1:0]};
	endfunction

	// The receiver changes ready only on falling edges, and only once per edge.
	initial begin : receiver
		int stretch;
		div_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				stretch     = rx_hold_len;
				rx_hold_len = 0;
				div_ch.ready <= 1'b0;
				repeat (stretch - 1) @(negedge clk);
			end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
				stretch = $urandom_range(1, 9);
				div_ch.ready <= 1'b0;
				repeat (stretch - 1) @(negedge clk);
			end else begin
				div_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [TONE_W-1:0]     edge_tones[5];
		logic [APB_DATA_W-1:0] edge_carriers[5];
		edge_tones = '{16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000};
		// Zero carrier gives sums at or below zero and sums far too small for a
		// 12-bit divisor. The top of the carrier range gives a divisor of exactly
		// one at zero tone and a divisor of zero just above. All ones is past the
		// stated range and exercises masking of the upper write bits. 122071 is
		// the smallest sum that still fits 4095, so a tone of -1 just falls out.
		// 32768 lets the most negative tone land on a sum of exactly zero.
		edge_carriers = '{32'd0, 32'd500000000, 32'hffffffff, 32'd122071, 32'd32768};

		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		tone_ch.valid       = 1'b0;
		tone_ch.tone_offset = '0;
		arst_n              = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register must read back zero straight out of reset.
		apb_access(1'b0, CARRIER_ADDR, '0);

		// Directed part: every edge tone against every edge carrier.
		foreach (edge_carriers[c]) begin
			set_carrier(edge_carriers[c]);
			foreach (edge_tones[t]) begin
				send_tone(edge_tones[t]);
			end
			drain_results();
		end

		// A write to the unmapped word must not disturb the carrier.
		apb_access(1'b1, SPARE_ADDR, 32'd1000);
		send_tone(16'h0000);
		drain_results();

		// Random phases, each under a fresh carrier. Some phases run without
		// any idling on one side or the other.
		for (int p = 0; p < 6; p++) begin
			set_carrier(pick_carrier());
			rx_steady = ($urandom_range(0, 2) == 0);
			tone_burst(60, $urandom_range(0, 2) != 0);
		end

		// The receiver holds off far longer than the pipeline is deep while the
		// sender keeps offering beats, so the block fills and stops taking tones.
		set_carrier(32'($urandom_range(200000, 490000000)));
		rx_steady   = 1'b0;
		rx_hold_len = 300;
		tone_burst(40, 1'b0);

		// Final stretch at full rate with no idling on either side.
		set_carrier(pick_carrier());
		rx_steady = 1'b1;
		tone_burst(50, 1'b0);

		// Give any stray result time to surface before the verdict.
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
